// ===== design/ihc_pkg.sv =====
// shared types, constants and checksum fold for the ipv4 header check
package ihc_pkg;

   localparam int WORD_W    = 16;
   localparam int SUM_W     = 21;
   localparam int COUNT_W   = 5;
   localparam int IHL_W     = 4;
   localparam int RSP_W     = 56;

   localparam logic [IHL_W-1:0]   MIN_IHL       = 4'd5;
   localparam logic [IHL_W-1:0]   VERSION_V4    = 4'd4;
   localparam logic [COUNT_W-1:0] MAX_SPAN      = 5'd30;
   localparam logic [COUNT_W-1:0] FRAG_WORD_IDX = 5'd3;
   localparam logic [COUNT_W-1:0] TTL_WORD_IDX  = 5'd4;
   localparam int                 DF_BIT        = 14;
   localparam int                 MF_BIT        = 13;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CSUM_ERR = 2'd1,
      STATUS_BAD_HDR  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]   protocol;
      logic [7:0]   time_to_live;
      logic         is_fragment;
      logic [12:0]  frag_offset;
      logic         more_fragments;
      logic         dont_fragment;
      logic [3:0]   header_len_words;
      logic [15:0]  checksum_value;
      status_type   status;
   } rsp_type;

   function automatic logic [WORD_W-1:0] fold_csum(input logic [SUM_W-1:0] s);
      logic [WORD_W:0] s1;
      logic [WORD_W:0] s2;
      s1 = {1'b0, s[WORD_W-1:0]} + {12'd0, s[SUM_W-1:WORD_W]};
      s2 = {1'b0, s1[WORD_W-1:0]} + {16'd0, s1[WORD_W]};
      return ~s2[WORD_W-1:0];
   endfunction

endpackage

// ===== design/ihc_accum.sv =====
// per-header word counter, checksum accumulator and field capture
module ihc_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [ihc_pkg::WORD_W-1:0]         word,
   output logic                               last_word,
   output ihc_pkg::rsp_type                   rsp
);
   import ihc_pkg::*;

   logic [COUNT_W-1:0] word_count_ff, word_count_in;
   logic [SUM_W-1:0]   running_sum_ff, running_sum_in;
   logic [IHL_W-1:0]   ihl_ff, ihl_in;
   logic [IHL_W-1:0]   version_ff, version_in;
   logic [WORD_W-1:0]  frag_ff, frag_in;
   logic [WORD_W-1:0]  ttl_proto_ff, ttl_proto_in;

   logic               sum_en;
   logic [SUM_W-1:0]   sum_cur;
   logic [IHL_W-1:0]   ihl_eff;
   logic [COUNT_W-1:0] span;
   logic [COUNT_W:0]   count_next;
   logic [WORD_W-1:0]  csum;

   always_comb begin
      ihl_in       = (word_count_ff == '0) ? word[11:8] : ihl_ff;
      version_in   = (word_count_ff == '0) ? word[15:12] : version_ff;
      frag_in      = (word_count_ff == FRAG_WORD_IDX) ? word : frag_ff;
      ttl_proto_in = (word_count_ff == TTL_WORD_IDX) ? word : ttl_proto_ff;

      sum_en     = word_count_ff < {ihl_in, 1'b0};
      sum_cur    = running_sum_ff + (sum_en ? {5'd0, word} : '0);
      ihl_eff    = (ihl_in < MIN_IHL) ? MIN_IHL : ihl_in;
      span       = {ihl_eff, 1'b0};
      count_next = {1'b0, word_count_ff} + 6'd1;
      last_word  = count_next >= {1'b0, span};

      word_count_in  = last_word ? '0 : count_next[COUNT_W-1:0];
      running_sum_in = last_word ? '0 : sum_cur;

      csum = fold_csum(sum_cur);
      rsp.checksum_value   = csum;
      rsp.header_len_words = ihl_in;
      rsp.dont_fragment    = frag_in[DF_BIT];
      rsp.more_fragments   = frag_in[MF_BIT];
      rsp.frag_offset      = frag_in[12:0];
      rsp.is_fragment      = frag_in != '0;
      rsp.time_to_live     = ttl_proto_in[15:8];
      rsp.protocol         = ttl_proto_in[7:0];
      if (csum != '0) begin
         rsp.status = STATUS_CSUM_ERR;
      end else if (version_in != VERSION_V4 || ihl_in < MIN_IHL) begin
         rsp.status = STATUS_BAD_HDR;
      end else begin
         rsp.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= '0;
         running_sum_ff <= '0;
      end else if (step) begin
         word_count_ff  <= word_count_in;
         running_sum_ff <= running_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ihl_ff       <= ihl_in;
         version_ff   <= version_in;
         frag_ff      <= frag_in;
         ttl_proto_ff <= ttl_proto_in;
      end
   end

`ifndef SYNTHESIS
   a_count_in_span: assert property (@(posedge clock) disable iff (reset)
      word_count_ff < MAX_SPAN)
      else $error("word count beyond longest header");
   a_sum_clear_at_start: assert property (@(posedge clock) disable iff (reset)
      word_count_ff == '0 |-> running_sum_ff == '0)
      else $error("sum not cleared at header start");
   a_ok_needs_v4: assert property (@(posedge clock) disable iff (reset)
      step && last_word && rsp.status == STATUS_OK |->
         version_in == VERSION_V4 && ihl_in >= MIN_IHL)
      else $error("ok status on bad header");
`endif

endmodule

// ===== design/ipv4_header_check.sv =====
// ipv4 header check top level: input register, header accumulator, result register
//
//  channel  dir  ports          payload
//  req      in   req_t*         tdata[15:0] header_word
//  rsp      out  rsp_t*         tdata[53:0] protocol .. status, one item per header
//
//  one header word per cycle unless a held result stalls; each word is registered at the
//  input, then the accumulator takes it and the result register captures the item on the last word
//  reset clears the word count, the running sum and both valid flags
//  a held result stalls only the header's last word; other words keep flowing
module ipv4_header_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [15:0]               req_tdata,   // [15:0] header_word
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ihc_pkg::RSP_W-1:0] rsp_tdata    // status, checksum_value,
                                                  // header_len_words, dont_fragment,
                                                  // more_fragments, frag_offset,
                                                  // is_fragment, time_to_live, protocol
);
   import ihc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]  in_word_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_next;
   logic               last_word;
   logic               advance;
   logic               rsp_free;

   ihc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .word      (in_word_ff),
      .last_word (last_word),
      .rsp       (rsp_next)
   );

   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      advance      = in_valid_ff && (!last_word || rsp_free);
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = req_tvalid || (in_valid_ff && !advance);
      rsp_valid_in = (advance && last_word) || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= in_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata;
      end
      if (advance && last_word) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid flags not cleared by reset");
   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff))
      else $error("stalled header word lost");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && last_word && rsp_valid_ff)
      else $error("input stalled without a held result");
   a_csum_zero_unless_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_CSUM_ERR |-> rsp_ff.checksum_value == '0)
      else $error("nonzero checksum without checksum error");
`endif

endmodule

// ===== tb/sv/tb_ipv4_header_check.sv =====
// testbench for ipv4_header_check: header word stream in, one checked result item per header
`timescale 1ns / 100ps

module tb_ipv4_header_check;

   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 650;

   typedef enum int {
      PH_FLOW,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH,
      PH_HOLD
   } phase_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES
   } fill_type;

   typedef struct {
      logic [15:0] word;
      phase_type   phase;
      bit          drain;
      bit          hold;
   } hdr_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata = '0;    // [15:0] header_word
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [ihc_pkg::RSP_W-1:0] rsp_tdata;         // status, checksum_value,
                                                 // header_len_words, dont_fragment,
                                                 // more_fragments, frag_offset,
                                                 // is_fragment, time_to_live, protocol

   hdr_word_type            words_to_send[$];
   ihc_pkg::rsp_type        expected_results[$];
   phase_type               cur_phase = PH_FLOW;
   logic                    hold_kick = 1'b0;
   int                      hold_left = 0;
   int                      failures = 0;
   int                      cycle_count = 0;
   int                      words_taken = 0;
   int                      results_seen = 0;
   int                      status_seen[3] = '{0, 0, 0};
   int                      holds_done = 0;

   // header tracking state
   logic [4:0]  hdr_pos = '0;
   logic [20:0] hdr_sum = '0;
   logic [3:0]  hdr_ihl = '0;
   logic [3:0]  hdr_version = '0;
   logic [15:0] hdr_frag = '0;
   logic [15:0] hdr_ttl_proto = '0;

   ipv4_header_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // complemented ones-complement sum, folded twice
   function automatic logic [15:0] csum_of(input logic [20:0] s);
      logic [31:0] t;
      t = {16'd0, s[15:0]} + {27'd0, s[20:16]};
      t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
      return ~t[15:0];
   endfunction

   task automatic track_word(input logic [15:0] w);
      ihc_pkg::rsp_type r;
      logic [15:0]      csum;
      int               span;
      if (hdr_pos == '0) begin
         hdr_ihl     = w[11:8];
         hdr_version = w[15:12];
      end
      if (hdr_pos == ihc_pkg::FRAG_WORD_IDX) hdr_frag = w;
      if (hdr_pos == ihc_pkg::TTL_WORD_IDX) hdr_ttl_proto = w;
      if (int'(hdr_pos) < 2 * int'(hdr_ihl)) hdr_sum = hdr_sum + {5'd0, w};
      span = 2 * int'((hdr_ihl < ihc_pkg::MIN_IHL) ? ihc_pkg::MIN_IHL : hdr_ihl);
      if (int'(hdr_pos) + 1 < span) begin
         hdr_pos = hdr_pos + 5'd1;
         return;
      end
      csum = csum_of(hdr_sum);
      if (csum != 16'h0000)
         r.status = ihc_pkg::STATUS_CSUM_ERR;
      else if (hdr_version != ihc_pkg::VERSION_V4 || hdr_ihl < ihc_pkg::MIN_IHL)
         r.status = ihc_pkg::STATUS_BAD_HDR;
      else
         r.status = ihc_pkg::STATUS_OK;
      r.checksum_value   = csum;
      r.header_len_words = hdr_ihl;
      r.dont_fragment    = hdr_frag[ihc_pkg::DF_BIT];
      r.more_fragments   = hdr_frag[ihc_pkg::MF_BIT];
      r.frag_offset      = hdr_frag[12:0];
      r.is_fragment      = (hdr_frag != 16'h0000);
      r.time_to_live     = hdr_ttl_proto[15:8];
      r.protocol         = hdr_ttl_proto[7:0];
      expected_results.push_back(r);
      hdr_pos = '0;
      hdr_sum = '0;
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned got_v);
      if (exp_v != got_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
         failures++;
      end
   endtask

   task automatic check_result(input logic [ihc_pkg::RSP_W-1:0] data);
      ihc_pkg::rsp_type want;
      ihc_pkg::rsp_type got;
      got = ihc_pkg::rsp_type'(data[$bits(ihc_pkg::rsp_type)-1:0]);
      results_seen++;
      if (expected_results.size() == 0) begin
         $error("result item with no header pending: tdata 0x%0h", data);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      status_seen[int'(want.status) % 3]++;
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("checksum_value", 32'(want.checksum_value), 32'(got.checksum_value));
      check_field("header_len_words", 32'(want.header_len_words),
                  32'(got.header_len_words));
      check_field("dont_fragment", 32'(want.dont_fragment), 32'(got.dont_fragment));
      check_field("more_fragments", 32'(want.more_fragments), 32'(got.more_fragments));
      check_field("frag_offset", 32'(want.frag_offset), 32'(got.frag_offset));
      check_field("is_fragment", 32'(want.is_fragment), 32'(got.is_fragment));
      check_field("time_to_live", 32'(want.time_to_live), 32'(got.time_to_live));
      check_field("protocol", 32'(want.protocol), 32'(got.protocol));
      check_field("tdata padding", 0,
                  32'(data[ihc_pkg::RSP_W-1:$bits(ihc_pkg::rsp_type)]));
   endtask

   task automatic queue_header(input logic [3:0] ver, input logic [3:0] ihl, input bit fix_sum,
                               input fill_type fill, input phase_type ph, input bit drain,
                               input bit hold);
      logic [15:0]  w[30];
      logic [20:0]  part;
      int           span;
      int           adj;
      hdr_word_type it;
      span = 2 * int'((ihl < ihc_pkg::MIN_IHL) ? ihc_pkg::MIN_IHL : ihl);
      for (int i = 0; i < span; i++) begin
         case (fill)
            FILL_ZERO: w[i] = 16'h0000;
            FILL_ONES: w[i] = 16'hffff;
            default: w[i] = 16'($urandom);
         endcase
      end
      w[0][15:8] = {ver, ihl};
      if (fill == FILL_RANDOM && $urandom_range(3) == 0) w[3] = 16'h0000;
      if (fix_sum && ihl != 4'd0) begin
         adj = (ihl >= ihc_pkg::MIN_IHL) ? 5 : 2 * int'(ihl) - 1;
         w[adj] = 16'h0000;
         part = '0;
         for (int i = 0; i < 2 * int'(ihl); i++) part = part + {5'd0, w[i]};
         w[adj] = csum_of(part);
      end
      for (int i = 0; i < span; i++) begin
         it.word  = w[i];
         it.phase = ph;
         it.drain = drain && (i == 0);
         it.hold  = hold && (i == 0);
         words_to_send.push_back(it);
      end
   endtask

   task automatic queue_random_header(input phase_type ph, input bit drain, input bit hold);
      int          pick;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      pick = $urandom_range(99);
      ver  = ihc_pkg::VERSION_V4;
      ihl  = ($urandom_range(9) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(5, 7));
      if (pick < 70) begin
         queue_header(ver, ihl, 1'b1, FILL_RANDOM, ph, drain, hold);
      end else if (pick < 80) begin
         queue_header(ver, ihl, 1'b0, FILL_RANDOM, ph, drain, hold);
      end else if (pick < 88) begin
         ver = 4'($urandom_range(15));
         if (ver == ihc_pkg::VERSION_V4) ver = 4'd6;
         queue_header(ver, ihl, 1'b1, FILL_RANDOM, ph, drain, hold);
      end else if (pick < 96) begin
         queue_header(ver, 4'($urandom_range(4)), 1'($urandom_range(1)), FILL_RANDOM, ph,
                      drain, hold);
      end else begin
         queue_header(4'($urandom), 4'($urandom), 1'b0, FILL_RANDOM, ph, drain, hold);
      end
   endtask

   task automatic build_stimulus();
      int        hdr_idx;
      int        total;
      bit        mid_drain_done;
      phase_type ph;
      // empty sum, wrong version: checksum wins over version
      queue_header(4'd0, 4'd0, 1'b0, FILL_ZERO, PH_FLOW, 1'b0, 1'b0);
      // good header, all-ones content
      queue_header(ihc_pkg::VERSION_V4, ihc_pkg::MIN_IHL, 1'b1, FILL_ONES, PH_FLOW,
                   1'b0, 1'b0);
      // short length and bad version with a good sum
      queue_header(4'd6, 4'd3, 1'b1, FILL_RANDOM, PH_FLOW, 1'b0, 1'b0);
      hdr_idx = 0;
      mid_drain_done = 1'b0;
      ph = PH_HOLD;
      while (words_to_send.size() < RANDOM_WORDS) begin
         total = words_to_send.size();
         if (hdr_idx >= 6 && hdr_idx % 8 == 6) ph = phase_type'($urandom_range(3));
         if (!mid_drain_done && total > RANDOM_WORDS / 2) begin
            mid_drain_done = 1'b1;
            queue_random_header(ph, 1'b1, 1'b0);
         end else begin
            queue_random_header(ph, hdr_idx == 0, hdr_idx == 0);
         end
         hdr_idx++;
      end
   endtask

   always @(posedge clock) begin : drive_req
      hdr_word_type nxt;
      bit           send;
      int           idle_pct;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         hold_kick  <= 1'b0;
      end else begin
         send = 1'b0;
         if (req_tvalid && req_tready) begin
            track_word(req_tdata);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (words_to_send.size() != 0) begin
               nxt = words_to_send[0];
               idle_pct = (nxt.phase == PH_SEND_IDLE) ? 67 : (nxt.phase == PH_BOTH) ? 6 : 0;
               send = !(nxt.drain && expected_results.size() != 0)
                      && ($urandom_range(99) >= idle_pct);
               if (send) begin
                  void'(words_to_send.pop_front());
                  req_tdata <= nxt.word;
                  cur_phase <= nxt.phase;
               end
            end
            req_tvalid <= send;
         end
         hold_kick <= send && nxt.hold;
      end
   end

   always @(posedge clock) begin : hold_timer
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin : watch_rsp
      int stall_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         stall_pct = (cur_phase == PH_RECV_STALL) ? 67 : (cur_phase == PH_BOTH) ? 6 : 0;
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (words_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      failures += expected_results.size();
      $display("%0d header words in, %0d result items checked in %0d cycles",
               words_taken, results_seen, cycle_count);
      $display("status ok %0d, checksum error %0d, bad header %0d; long receiver hold-offs %0d",
               status_seen[0], status_seen[1], status_seen[2], holds_done);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
